// File: rtl/core/dra_pkg.sv
// dra_pkg: shared types and constants of the dns reply address extractor
// no dependencies; used by dra_in_stage, dra_parser and the top level
`default_nettype none

package dra_pkg;

    localparam int TRANSPORT_HEADER_BYTES = 8;
    localparam int NAME_HEADER_BYTES      = 12;

    // offsets within the dns header of the byte that completes each word
    localparam int HDR_ID_END      = 1;
    localparam int HDR_FLAGS_END   = 3;
    localparam int HDR_QDCOUNT_END = 5;
    localparam int HDR_ANCOUNT_END = 7;

    // offsets within an answer record
    localparam logic [3:0] REC_TYPE_HI    = 4'd2;
    localparam logic [3:0] REC_TYPE_LO    = 4'd3;
    localparam logic [3:0] REC_RDLEN_HI   = 4'd10;
    localparam logic [3:0] REC_RDLEN_LO   = 4'd11;
    localparam logic [3:0] REC_RDATA_BEG  = 4'd12;
    localparam logic [3:0] REC_RDATA_LAST = 4'd15;

    localparam logic [15:0] RCODE_MASK      = 16'h8F00;
    localparam logic [15:0] RCODE_NXDOMAIN  = 16'h8300;
    localparam logic [15:0] RCODE_REFUSED   = 16'h8500;
    localparam logic [15:0] QR_MASK         = 16'h0080;
    localparam logic [15:0] QDCOUNT_ONE     = 16'h0100;
    localparam logic [15:0] QUESTION_TAIL   = 16'd4;
    localparam logic [7:0]  TYPE_A_LO       = 8'd1;
    localparam logic [15:0] EXPECTED_ID_RST = 16'hCDAB;
    localparam logic [31:0] NO_ADDRESS      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        PH_HEADER     = 3'd0,
        PH_LABEL_LEN  = 3'd1,
        PH_LABEL_SKIP = 3'd2,
        PH_TAIL       = 3'd3,
        PH_RECORD     = 3'd4,
        PH_A_RECORD   = 3'd5,
        PH_RDATA_SKIP = 3'd6,
        PH_DONE       = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_FAILED   = 2'd1,
        ST_NOT_OURS = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       frame_end;
    } step_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] ip_address;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/dns_reply_address_extractor_top.sv
// dns_reply_address_extractor_top: byte stream in, one dns a-record result per frame out
// depends on dra_pkg, dra_in_stage and dra_parser
// a frame's result reaches m_tdata via the input register, then the result register
// throughput: one byte per cycle, set by the single-pass update between the input
// register and the result register; a stalled result holds back only the next last byte
// reset: clears parse state, both stages and restores expected_id to 0xcdab
`default_nettype none

module dns_reply_address_extractor_top #(
    parameter int LINK_HEADER_BYTES = 14,
    parameter int NET_HEADER_BYTES  = 20,
    parameter int MAX_RECORDS       = 100
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // frame_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [1:0] status, [33:2] ip_address, [39:34] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // expected_id
);

    dra_pkg::step_t   step;
    dra_pkg::result_t result;
    logic             result_valid;
    logic             advance;
    logic             fire;
    logic [15:0]      expected_id_reg;
    logic             out_valid_reg;
    dra_pkg::result_t out_reg;

    assign advance   = !step.frame_end || !out_valid_reg || m_tready;
    assign fire      = step.valid && advance;
    assign cfg_ready = 1'b1;

    dra_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .step     (step)
    );

    dra_parser #(
        .LINK_HEADER_BYTES (LINK_HEADER_BYTES),
        .NET_HEADER_BYTES  (NET_HEADER_BYTES),
        .MAX_RECORDS       (MAX_RECORDS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .fire         (fire),
        .expected_id  (expected_id_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= dra_pkg::EXPECTED_ID_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            expected_id_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.ip_address, out_reg.status};

    // a held result is never overwritten by the next frame's result
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !result_valid)
        else $error("result register overwritten while stalled");

    // any status other than found carries the all-ones address
    a_fail_addr : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_reg.status != dra_pkg::ST_FOUND))
            |-> (out_reg.ip_address == dra_pkg::NO_ADDRESS))
        else $error("failed result with a non all-ones address");

    // a new result only follows a processed last byte
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(fire && step.frame_end))
        else $error("result without a frame end");

    // a stalled last byte keeps the input register closed
    a_last_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        (step.valid && step.frame_end && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while the last byte is stalled");

endmodule

`default_nettype wire

// File: rtl/core/dra_in_stage.sv
// dra_in_stage: input register for frame bytes
// depends on dra_pkg (step_t)
`default_nettype none

module dra_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] data_byte
    input  wire logic          s_tlast,   // frame_end
    input  wire logic          advance,
    output dra_pkg::step_t     step
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign s_tready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign step.valid     = valid_reg;
    assign step.data_byte = data_reg;
    assign step.frame_end = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/dra_parser.sv
// dra_parser: frame parse state and per-byte update logic
// depends on dra_pkg (phase_t, status_t, step_t, result_t, constants)
`default_nettype none

module dra_parser #(
    parameter int LINK_HEADER_BYTES = 14,
    parameter int NET_HEADER_BYTES  = 20,
    parameter int MAX_RECORDS       = 100
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dra_pkg::step_t    step,
    input  wire logic              fire,
    input  wire logic [15:0]       expected_id,
    output logic                   result_valid,
    output dra_pkg::result_t       result
);

    localparam int DNS_START = LINK_HEADER_BYTES + NET_HEADER_BYTES
                               + dra_pkg::TRANSPORT_HEADER_BYTES;
    localparam int POS_W = $clog2(DNS_START + dra_pkg::NAME_HEADER_BYTES + 1);
    localparam int RC_W  = $clog2(MAX_RECORDS + 1);

    dra_pkg::phase_t  phase_reg,  phase_next,  phase_step;
    dra_pkg::status_t verdict_reg, verdict_next, verdict_step;
    logic [POS_W-1:0] pos_reg,    pos_next,    pos_step;
    logic [15:0]      hw_reg,     hw_next,     hw_step;
    logic [15:0]      skip_reg,   skip_next,   skip_step;
    logic [RC_W-1:0]  rc_reg,     rc_next,     rc_step;
    logic [3:0]       off_reg,    off_next,    off_step;
    logic [31:0]      acc_reg,    acc_next,    acc_step;

    logic [7:0]       b;
    logic [POS_W-1:0] rel;
    logic [15:0]      hw_shift;
    logic [15:0]      skip_dec;
    logic [15:0]      rdlen;
    logic [RC_W-1:0]  rc_inc;

    assign b        = step.data_byte;
    assign rel      = pos_reg - POS_W'(DNS_START);
    assign hw_shift = {b, hw_reg[15:8]};
    assign skip_dec = skip_reg - 16'd1;
    assign rdlen    = {hw_reg[7:0], b};
    assign rc_inc   = rc_reg + RC_W'(1);

    // per-byte next state
    always_comb
    begin
        phase_step   = phase_reg;
        verdict_step = verdict_reg;
        pos_step     = pos_reg;
        hw_step      = hw_reg;
        skip_step    = skip_reg;
        rc_step      = rc_reg;
        off_step     = off_reg;
        acc_step     = acc_reg;
        unique case (phase_reg)
            dra_pkg::PH_HEADER:
            begin
                pos_step = pos_reg + POS_W'(1);
                if (pos_reg >= POS_W'(DNS_START))
                begin
                    hw_step = hw_shift;
                    if (rel == POS_W'(dra_pkg::HDR_ID_END))
                    begin
                        if (hw_shift != expected_id)
                        begin
                            verdict_step = dra_pkg::ST_NOT_OURS;
                            phase_step   = dra_pkg::PH_DONE;
                        end
                    end
                    else if (rel == POS_W'(dra_pkg::HDR_FLAGS_END))
                    begin
                        if (((hw_shift & dra_pkg::RCODE_MASK) == dra_pkg::RCODE_NXDOMAIN)
                            || ((hw_shift & dra_pkg::RCODE_MASK) == dra_pkg::RCODE_REFUSED)
                            || ((hw_shift & dra_pkg::QR_MASK) == 16'd0))
                        begin
                            verdict_step = dra_pkg::ST_FAILED;
                            phase_step   = dra_pkg::PH_DONE;
                        end
                    end
                    else if (rel == POS_W'(dra_pkg::HDR_QDCOUNT_END))
                    begin
                        if (hw_shift != dra_pkg::QDCOUNT_ONE)
                        begin
                            verdict_step = dra_pkg::ST_FAILED;
                            phase_step   = dra_pkg::PH_DONE;
                        end
                    end
                    else if (rel == POS_W'(dra_pkg::HDR_ANCOUNT_END))
                    begin
                        if (hw_shift == 16'd0)
                        begin
                            verdict_step = dra_pkg::ST_FAILED;
                            phase_step   = dra_pkg::PH_DONE;
                        end
                    end
                    else if (rel == POS_W'(dra_pkg::NAME_HEADER_BYTES - 1))
                    begin
                        phase_step = dra_pkg::PH_LABEL_LEN;
                    end
                end
            end
            dra_pkg::PH_LABEL_LEN:
            begin
                if (b == 8'd0)
                begin
                    skip_step  = dra_pkg::QUESTION_TAIL;
                    phase_step = dra_pkg::PH_TAIL;
                end
                else
                begin
                    skip_step  = {8'd0, b};
                    phase_step = dra_pkg::PH_LABEL_SKIP;
                end
            end
            dra_pkg::PH_LABEL_SKIP:
            begin
                skip_step = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_step = dra_pkg::PH_LABEL_LEN;
                end
            end
            dra_pkg::PH_TAIL, dra_pkg::PH_RDATA_SKIP:
            begin
                skip_step = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    off_step   = 4'd0;
                    phase_step = dra_pkg::PH_RECORD;
                end
            end
            dra_pkg::PH_RECORD:
            begin
                off_step = off_reg + 4'd1;
                if (off_reg == dra_pkg::REC_TYPE_HI || off_reg == dra_pkg::REC_RDLEN_HI)
                begin
                    hw_step = {8'd0, b};
                end
                else if (off_reg == dra_pkg::REC_TYPE_LO)
                begin
                    if (hw_reg == 16'd0 && b == dra_pkg::TYPE_A_LO)
                    begin
                        phase_step = dra_pkg::PH_A_RECORD;
                    end
                end
                else if (off_reg == dra_pkg::REC_RDLEN_LO)
                begin
                    skip_step = rdlen;
                    rc_step   = rc_inc;
                    if (rc_inc >= RC_W'(MAX_RECORDS))
                    begin
                        verdict_step = dra_pkg::ST_NONE;
                        phase_step   = dra_pkg::PH_DONE;
                    end
                    else if (rdlen == 16'd0)
                    begin
                        off_step   = 4'd0;
                        phase_step = dra_pkg::PH_RECORD;
                    end
                    else
                    begin
                        phase_step = dra_pkg::PH_RDATA_SKIP;
                    end
                end
            end
            dra_pkg::PH_A_RECORD:
            begin
                off_step = off_reg + 4'd1;
                if (off_reg >= dra_pkg::REC_RDATA_BEG)
                begin
                    acc_step = {b, acc_reg[31:8]};
                    if (off_reg == dra_pkg::REC_RDATA_LAST)
                    begin
                        verdict_step = dra_pkg::ST_FOUND;
                        phase_step   = dra_pkg::PH_DONE;
                    end
                end
            end
            dra_pkg::PH_DONE:
            begin
                phase_step = dra_pkg::PH_DONE;
            end
            default:
            begin
                phase_step = dra_pkg::PH_DONE;
            end
        endcase
    end

    // register next values, returned to their reset values after the frame's last byte
    always_comb
    begin
        phase_next   = phase_reg;
        verdict_next = verdict_reg;
        pos_next     = pos_reg;
        hw_next      = hw_reg;
        skip_next    = skip_reg;
        rc_next      = rc_reg;
        off_next     = off_reg;
        acc_next     = acc_reg;
        if (fire)
        begin
            if (step.frame_end)
            begin
                phase_next   = dra_pkg::PH_HEADER;
                verdict_next = dra_pkg::ST_NONE;
                pos_next     = '0;
                hw_next      = '0;
                skip_next    = '0;
                rc_next      = '0;
                off_next     = '0;
                acc_next     = '0;
            end
            else
            begin
                phase_next   = phase_step;
                verdict_next = verdict_step;
                pos_next     = pos_step;
                hw_next      = hw_step;
                skip_next    = skip_step;
                rc_next      = rc_step;
                off_next     = off_step;
                acc_next     = acc_step;
            end
        end
    end

    // result outputs
    always_comb
    begin
        result_valid      = fire && step.frame_end;
        result.status     = verdict_step;
        result.ip_address = (verdict_step == dra_pkg::ST_FOUND) ? acc_step
                                                                 : dra_pkg::NO_ADDRESS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= dra_pkg::PH_HEADER;
            verdict_reg <= dra_pkg::ST_NONE;
            pos_reg     <= '0;
            hw_reg      <= '0;
            skip_reg    <= '0;
            rc_reg      <= '0;
            off_reg     <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            verdict_reg <= verdict_next;
            pos_reg     <= pos_next;
            hw_reg      <= hw_next;
            skip_reg    <= skip_next;
            rc_reg      <= rc_next;
            off_reg     <= off_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

`default_nettype wire
